[hw/rtl/spbp_pkg.sv]
`timescale 1ns / 1ps

package spbp_pkg;

  // Activation format and plane count are fixed by the sign-magnitude scheme
  localparam int ACT_BITS = 4;
  localparam int PLANES   = 4;
  localparam int IN_W     = 64;
  localparam int RES_W    = 12;
  localparam int CNT_W    = 11;

  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic signed [RES_W-1:0] res_t;

  // Queue status seen by the front (full) and the back (empty)
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

[hw/rtl/spbp_fifo.sv]
`timescale 1ns / 1ps

module spbp_fifo import spbp_pkg::*; #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              pop,
  output logic [DATA_W-1:0] rd_data,
  output fifo_stat_t        stat
);

  // Two entries: enough to keep one transaction per cycle flowing
  logic [DATA_W-1:0] mem_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data    = mem_r[rd_ptr_r];
  assign stat.full  = cnt_r[1];
  assign stat.empty = (cnt_r == 2'd0);

endmodule

[hw/rtl/spbp_front.sv]
`timescale 1ns / 1ps

module spbp_front import spbp_pkg::*; #(
  parameter int LANES    = 16,
  parameter int WGT_BITS = 4,
  parameter int DATA_W   = LANES * (PLANES + 1 + WGT_BITS) + 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  cnt_t              cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [IN_W-1:0]   in_packed_activations,
  input  logic [IN_W-1:0]   in_packed_weights,
  input  fifo_stat_t        stat,
  output logic              push,
  output logic [DATA_W-1:0] entry
);

  cnt_t round_count_r, round_count_nxt;
  cnt_t rounds_done_r, rounds_done_nxt;
  cnt_t next_cnt;
  logic last;

  logic [LANES*PLANES-1:0]   mag;
  logic [LANES-1:0]          neg;
  logic [LANES*WGT_BITS-1:0] wgts;

  assign in_ready = !stat.full;
  assign push     = in_valid && in_ready;

  // Split each activation into sign and magnitude; -8 negates to itself (1000)
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      neg[i] = in_packed_activations[ACT_BITS*i + ACT_BITS - 1];
      mag[PLANES*i +: PLANES] = neg[i] ?
        PLANES'(~in_packed_activations[ACT_BITS*i +: ACT_BITS] + 1'b1) :
        PLANES'(in_packed_activations[ACT_BITS*i +: ACT_BITS]);
      wgts[WGT_BITS*i +: WGT_BITS] = in_packed_weights[WGT_BITS*i +: WGT_BITS];
    end
  end

  // Round counter: flag the configured final round, then restart
  always_comb begin
    next_cnt        = rounds_done_r + 1'b1;
    last            = (round_count_r != '0) && (next_cnt == round_count_r);
    round_count_nxt = round_count_r;
    rounds_done_nxt = rounds_done_r;
    if (cfg_wr_en) begin
      round_count_nxt = cfg_wr_data;
      rounds_done_nxt = '0;
    end else if (push) begin
      rounds_done_nxt = last ? '0 : next_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_count_r <= '0;
      rounds_done_r <= '0;
    end else begin
      round_count_r <= round_count_nxt;
      rounds_done_r <= rounds_done_nxt;
    end
  end

  assign entry = {last, wgts, neg, mag};

endmodule

[hw/rtl/spbp_back.sv]
`timescale 1ns / 1ps

module spbp_back import spbp_pkg::*; #(
  parameter int LANES    = 16,
  parameter int WGT_BITS = 4,
  parameter int DATA_W   = LANES * (PLANES + 1 + WGT_BITS) + 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fifo_stat_t        stat,
  input  logic [DATA_W-1:0] entry,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output res_t              out_dot_result,
  output logic              out_last_round
);

  localparam int PSUM_W = $clog2(LANES) + WGT_BITS + 1;
  localparam int TREE_N = 1 << $clog2(LANES);

  logic [LANES*PLANES-1:0]   mag;
  logic [LANES-1:0]          neg;
  logic [LANES*WGT_BITS-1:0] wgts;
  logic                      last;

  logic signed [PSUM_W-1:0] psum [PLANES];
  logic signed [PSUM_W-1:0] w_ext;
  logic signed [PSUM_W-1:0] node [PLANES][2*TREE_N];

  logic signed [PSUM_W-1:0] psum_r [PLANES];
  logic                     s1_valid_r, s1_valid_nxt;
  logic                     s1_last_r;
  logic                     s2_load, s1_load;
  logic                     out_valid_r, out_valid_nxt;
  res_t                     dot_r, total;
  logic                     last_r;

  assign {last, wgts, neg, mag} = entry;

  // Plane partial sums: each spike adds or subtracts its lane's weight.
  // Lane terms sit at the leaves of a balanced adder tree per plane.
  always_comb begin
    w_ext = '0;
    for (int j = 0; j < PLANES; j++) begin
      for (int k = 0; k < 2*TREE_N; k++) begin
        node[j][k] = '0;
      end
    end
    for (int i = 0; i < LANES; i++) begin
      w_ext = PSUM_W'($signed(wgts[WGT_BITS*i +: WGT_BITS]));
      for (int j = 0; j < PLANES; j++) begin
        if (mag[PLANES*i + j]) begin
          node[j][TREE_N + i] = neg[i] ? -w_ext : w_ext;
        end
      end
    end
    for (int j = 0; j < PLANES; j++) begin
      for (int k = TREE_N - 1; k >= 1; k--) begin
        node[j][k] = node[j][2*k] + node[j][2*k + 1];
      end
      psum[j] = node[j][1];
    end
  end

  // Combine planes with their binary weights; the exact sum fits RES_W
  always_comb begin
    total = '0;
    for (int j = 0; j < PLANES; j++) begin
      total = total + (RES_W'(psum_r[j]) <<< j);
    end
  end

  assign s2_load      = s1_valid_r && (!out_valid_r || out_ready);
  assign s1_load      = !s1_valid_r || s2_load;
  assign pop          = !stat.empty && s1_load;
  assign s1_valid_nxt = s1_load ? !stat.empty : s1_valid_r;
  assign out_valid_nxt = s2_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int j = 0; j < PLANES; j++) begin
        psum_r[j] <= psum[j];
      end
      s1_last_r <= last;
    end
    if (s2_load) begin
      dot_r  <= total;
      last_r <= s1_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_dot_result = dot_r;
  assign out_last_round = last_r;

endmodule

[hw/rtl/spike_bitplane_dot_product.sv]
`timescale 1ns / 1ps

// Bit-plane sign-magnitude dot product of sixteen 4-bit activations with
// sixteen signed weights, one result per round.
// Input channel (in_valid/in_ready): one round per transaction, carrying the
// packed activations and weights. Output channel (out_valid/out_ready): one
// transaction per round with the signed dot product and the last-round flag.
// Configuration: cfg_wr_en with cfg_wr_data sets the rounds per job and
// restarts the round counter; write only while no round is in flight.
// Path: an accepted round is written to the queue, its plane sums are then
// registered, and then the plane combine is registered in the output register.
// Throughput: one round per cycle; the plane-sum stage and the output
// register each hold one round and advance every cycle the sink takes data.
// Stall: while out_ready is low the output holds; the pipeline stage and the
// two-entry queue keep absorbing rounds, and in_ready drops once it fills.
// Reset (rst_n low, synchronous): empties queue and pipeline, clears the
// round count to zero (no last flag) and the round counter.
module spike_bitplane_dot_product import spbp_pkg::*; #(
  parameter int LANES    = 16,
  parameter int WGT_BITS = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  cnt_t            cfg_wr_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [IN_W-1:0] in_packed_activations,
  input  logic [IN_W-1:0] in_packed_weights,
  output logic            out_valid,
  input  logic            out_ready,
  output res_t            out_dot_result,
  output logic            out_last_round
);

  // Queue entry: last flag, weights, spike signs, spike magnitudes
  localparam int DATA_W = LANES * (PLANES + 1 + WGT_BITS) + 1;

  fifo_stat_t        stat;
  logic              push, pop;
  logic [DATA_W-1:0] wr_entry, rd_entry;

  // Front: accept rounds, split into spikes, tag the last round
  spbp_front #(
    .LANES    (LANES),
    .WGT_BITS (WGT_BITS),
    .DATA_W   (DATA_W)
  ) u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_packed_activations (in_packed_activations),
    .in_packed_weights     (in_packed_weights),
    .stat                  (stat),
    .push                  (push),
    .entry                 (wr_entry)
  );

  // Decouple front and back so either side can stall alone
  spbp_fifo #(
    .DATA_W (DATA_W)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (wr_entry),
    .pop     (pop),
    .rd_data (rd_entry),
    .stat    (stat)
  );

  // Back: plane sums, shift-combine, output register
  spbp_back #(
    .LANES    (LANES),
    .WGT_BITS (WGT_BITS),
    .DATA_W   (DATA_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .stat           (stat),
    .entry          (rd_entry),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_dot_result (out_dot_result),
    .out_last_round (out_last_round)
  );

endmodule

[hw/rtl/spbp_checker.sv]
`timescale 1ns / 1ps

module spbp_checker import spbp_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic cfg_wr_en,
  input cnt_t cfg_wr_data,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input res_t out_dot_result,
  input logic out_last_round
);

  // Track whether the round count is zero (no last flag expected)
  logic cnt_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_zero_r <= 1'b1;
    end else if (cfg_wr_en) begin
      cnt_zero_r <= (cfg_wr_data == '0);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dot_result)
                                && $stable(out_last_round))
    else $error("output changed while stalled");

  a_no_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && cnt_zero_r |-> !out_last_round)
    else $error("last flag raised with zero round count");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready right after reset");

endmodule

bind spike_bitplane_dot_product spbp_checker u_spbp_checker (.*);

[sim/tb_spike_bitplane_dot_product.sv]
`timescale 1ns / 1ps

module tb_spike_bitplane_dot_product;
  import spbp_pkg::*;

  localparam int LANE_N      = 16;
  localparam int WGT_W       = 4;
  localparam int HALF_PERIOD = 10;
  localparam int RESET_LEN   = 10;
  // Hold-off length of the deliberate receiver stall
  localparam int LONG_HOLD   = 300;
  // Cycles with no transaction on either side before the run is aborted
  localparam int QUIET_LIMIT = 2000;
  // Settle margin after a drain before the round count is rewritten
  localparam int SETTLE      = 4;
  localparam int DRAIN_TAIL  = 10;
  localparam int DIR_ROWS    = 15;

  typedef struct packed {
    res_t dot;
    logic last;
  } round_result_t;

  typedef struct packed {
    logic [IN_W-1:0] acts;
    logic [IN_W-1:0] wgts;
    logic            typed;
    res_t            dot;
    logic            last;
  } dir_row_t;

  logic            clk;
  logic            rst_n;
  logic            cfg_wr_en;
  cnt_t            cfg_wr_data;
  logic            in_valid;
  logic            in_ready;
  logic [IN_W-1:0] in_packed_activations;
  logic [IN_W-1:0] in_packed_weights;
  logic            out_valid;
  logic            out_ready;
  res_t            out_dot_result;
  logic            out_last_round;

  // Typed expectation traveling alongside the payload currently offered
  logic            cur_typed;
  res_t            cur_dot;
  logic            cur_last;

  // Predictor copy of the block's configuration and round counter
  cnt_t            round_count_q;
  cnt_t            rounds_done_q;

  round_result_t   pending_results[$];
  int              mismatch_count;
  int              quiet_cycles;
  bit              idle_en;
  bit              hold_req;
  dir_row_t        dir_rows [DIR_ROWS];
  logic [3:0]      corner_nibbles [5];

  spike_bitplane_dot_product #(
    .LANES    (LANE_N),
    .WGT_BITS (WGT_W)
  ) i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_packed_activations (in_packed_activations),
    .in_packed_weights     (in_packed_weights),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_dot_result        (out_dot_result),
    .out_last_round        (out_last_round)
  );

  always #HALF_PERIOD clk = ~clk;

  // Split each activation into sign-magnitude bit planes, accumulate signed
  // weights per plane, then weight plane j by 2^j.
  function automatic res_t planes_dot(input logic [IN_W-1:0] acts,
                                      input logic [IN_W-1:0] wgts);
    int                        partial [PLANES];
    int                        total;
    logic signed [ACT_BITS-1:0] a_lane;
    logic signed [WGT_W-1:0]    w_lane;
    logic [PLANES-1:0]          mag;
    bit                         neg;
    total = 0;
    for (int j = 0; j < PLANES; j++) partial[j] = 0;
    for (int i = 0; i < LANE_N; i++) begin
      a_lane = acts[ACT_BITS*i +: ACT_BITS];
      w_lane = wgts[WGT_W*i +: WGT_W];
      neg    = a_lane < 0;
      // -8 negates to itself, which is exactly magnitude 1000
      mag    = neg ? -a_lane : a_lane;
      for (int j = 0; j < PLANES; j++) begin
        if (mag[j]) partial[j] += neg ? -int'(w_lane) : int'(w_lane);
      end
    end
    for (int j = 0; j < PLANES; j++) total += partial[j] * (1 << j);
    return total[RES_W-1:0];
  endfunction

  // Advance the round counter for one accepted round and queue its result
  task automatic absorb_round();
    round_result_t r;
    cnt_t          nxt;
    nxt    = rounds_done_q + 1'b1;
    r.dot  = planes_dot(in_packed_activations, in_packed_weights);
    r.last = (round_count_q != '0) && (nxt == round_count_q);
    rounds_done_q = r.last ? '0 : nxt;
    if (cur_typed) begin
      r.dot  = cur_dot;
      r.last = cur_last;
    end
    pending_results.push_back(r);
  endtask

  // Predict at every accepted input transaction
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) absorb_round();
  end

  // Check every accepted output transaction against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: dot_result %0d last_round %0b",
               out_dot_result, out_last_round);
        mismatch_count++;
      end else begin
        if (out_dot_result !== pending_results[0].dot) begin
          $error("dot_result: expected %0d, got %0d",
                 pending_results[0].dot, out_dot_result);
          mismatch_count++;
        end
        if (out_last_round !== pending_results[0].last) begin
          $error("last_round: expected %0b, got %0b",
                 pending_results[0].last, out_last_round);
          mismatch_count++;
        end
        void'(pending_results.pop_front());
      end
    end
  end

  // Abort when neither channel moves a transaction for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Receiver: mostly ready, random stall bursts when idling is enabled,
  // and one long hold-off on request so the pipeline backs up into in_ready.
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Mix fully random words, lanes drawn from the corner values, and words repeating one random nibble
  function automatic logic [IN_W-1:0] lane_word();
    logic [IN_W-1:0] w;
    logic [3:0]      nib;
    case ($urandom_range(0, 3))
      0, 1: w = {$urandom, $urandom};
      2: begin
        for (int i = 0; i < LANE_N; i++) w[4*i +: 4] = corner_nibbles[$urandom_range(0, 4)];
      end
      default: begin
        nib = 4'($urandom_range(0, 15));
        w   = {LANE_N{nib}};
      end
    endcase
    return w;
  endfunction

  // Offer one round; hold valid and payload until the block takes it.
  // Called and returns at a falling edge.
  task automatic send_round(input logic [IN_W-1:0] acts, input logic [IN_W-1:0] wgts,
                            input logic typed, input res_t dot, input logic last);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid              <= 1'b1;
    in_packed_activations <= acts;
    in_packed_weights     <= wgts;
    cur_typed             <= typed;
    cur_dot               <= dot;
    cur_last              <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Reprogram the round count while idle, then run a burst of random rounds
  task automatic run_phase(input cnt_t rc, input int n_rounds, input bit with_idle,
                           input bit long_hold, input bit mid_drain);
    drain();
    repeat (SETTLE) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= rc;
    @(negedge clk);
    cfg_wr_en     <= 1'b0;
    // A write also restarts the job
    round_count_q = rc;
    rounds_done_q = '0;
    idle_en       = with_idle;
    if (long_hold) hold_req = 1'b1;
    for (int n = 0; n < n_rounds; n++) begin
      if (mid_drain && n == n_rounds / 2) drain();
      send_round(lane_word(), lane_word(), 1'b0, '0, 1'b0);
    end
  endtask

  initial begin
    clk                   = 1'b0;
    rst_n                 = 1'b0;
    cfg_wr_en             = 1'b0;
    cfg_wr_data           = '0;
    in_valid              = 1'b0;
    in_packed_activations = '0;
    in_packed_weights     = '0;
    out_ready             = 1'b0;
    cur_typed             = 1'b0;
    cur_dot               = '0;
    cur_last              = 1'b0;
    round_count_q         = '0;
    rounds_done_q         = '0;
    mismatch_count        = 0;
    quiet_cycles          = 0;
    idle_en               = 1'b1;
    hold_req              = 1'b0;
    corner_nibbles        = '{4'h8, 4'h7, 4'hF, 4'h0, 4'h1};

    // Directed rounds after reset: round count is zero, so no last flag.
    // Extremes carry typed results; mixed patterns go through the predictor.
    dir_rows = '{
      '{64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000, 1'b1,     12'sd0, 1'b0},
      '{64'h7777_7777_7777_7777, 64'h7777_7777_7777_7777, 1'b1,   12'sd784, 1'b0},
      // all lanes most negative: top of the result range
      '{64'h8888_8888_8888_8888, 64'h8888_8888_8888_8888, 1'b1,  12'sd1024, 1'b0},
      // bottom of the result range, both ways round
      '{64'h8888_8888_8888_8888, 64'h7777_7777_7777_7777, 1'b1, -12'sd896, 1'b0},
      '{64'h7777_7777_7777_7777, 64'h8888_8888_8888_8888, 1'b1, -12'sd896, 1'b0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 64'h1111_1111_1111_1111, 1'b1,  -12'sd16, 1'b0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,    12'sd16, 1'b0},
      '{64'h8888_8888_8888_8888, 64'h1111_1111_1111_1111, 1'b1, -12'sd128, 1'b0},
      // single most negative activation in the top lane, then the bottom lane
      '{64'h8000_0000_0000_0000, 64'hF000_0000_0000_0000, 1'b1,     12'sd8, 1'b0},
      '{64'h0000_0000_0000_0008, 64'h0000_0000_0000_0007, 1'b1,  -12'sd56, 1'b0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000, 1'b1,     12'sd0, 1'b0},
      '{64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b0,     12'sd0, 1'b0},
      '{64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0,     12'sd0, 1'b0},
      '{64'h1234_5678_9ABC_DEF0, 64'h8877_6655_4433_2211, 1'b0,     12'sd0, 1'b0},
      '{64'h0F0F_0F0F_0F0F_0F0F, 64'hF0F0_F0F0_F0F0_F0F0, 1'b0,     12'sd0, 1'b0}
    };

    // Hold reset for the first cycles, then release at a falling edge
    repeat (RESET_LEN) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[k]) begin
      send_round(dir_rows[k].acts, dir_rows[k].wgts, dir_rows[k].typed,
                 dir_rows[k].dot, dir_rows[k].last);
    end

    // Random phases: last flag on every round, a long receiver hold-off,
    // zero count (never last), a count of 1024 with a mid-job drain, a count of two,
    // a random small count, and a final stretch without any idling.
    run_phase(cnt_t'(1), 40, 1'b1, 1'b0, 1'b0);
    run_phase(cnt_t'(3), 200, 1'b1, 1'b1, 1'b0);
    run_phase(cnt_t'(0), 150, 1'b0, 1'b0, 1'b0);
    run_phase(cnt_t'(1024), 1100, 1'b1, 1'b0, 1'b1);
    run_phase(cnt_t'(2), 100, 1'b1, 1'b0, 1'b0);
    run_phase(cnt_t'($urandom_range(4, 17)), 200, 1'b1, 1'b0, 1'b0);
    run_phase(cnt_t'(7), 200, 1'b0, 1'b0, 1'b0);

    // Let the pipeline empty, then allow a few more cycles for stray output
    drain();
    repeat (DRAIN_TAIL) @(negedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
